// ----- rtl/image_window_convolution_macros.svh -----
// Assertion helpers for the window convolution block.
`ifndef IMAGE_WINDOW_CONVOLUTION_MACROS_SVH
`define IMAGE_WINDOW_CONVOLUTION_MACROS_SVH

// Clocked on clk_i, off while reset is held.
`define IWC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked on clk_i, also checked during reset.
`define IWC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/iwc_pkg.sv -----
`timescale 1ns / 1ps
package iwc_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int CHANNELS_DEF  = 3;

  localparam int PIX_W    = 24;
  localparam int SAMPLE_W = 8;
  localparam int COEF_W   = 8;
  localparam int PROD_W   = 17;
  localparam int OUT_W    = 21;
  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 13;
  localparam int ROW_W    = 14;
  localparam int CFG_W    = 64;
  localparam int IDX_W    = 3;
  localparam int NCOEF    = 27;

  localparam logic [HEIGHT_W-1:0] HEIGHT_LIMIT = 13'd4096;

  localparam logic [IDX_W-1:0] REG_MODE   = 3'd0;
  localparam logic [IDX_W-1:0] REG_WIDTH  = 3'd1;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 3'd2;
  localparam logic [IDX_W-1:0] REG_SHIFT  = 3'd3;
  localparam logic [IDX_W-1:0] REG_BANK_A = 3'd4;
  localparam logic [IDX_W-1:0] REG_BANK_B = 3'd5;
  localparam logic [IDX_W-1:0] REG_BANK_C = 3'd6;
  localparam logic [IDX_W-1:0] REG_BANK_D = 3'd7;

  localparam logic [1:0] MODE_SPLIT    = 2'd0;
  localparam logic [1:0] MODE_PRESERVE = 2'd1;
  localparam logic [1:0] MODE_SUMMED   = 2'd2;
  // unused encoding, behaves as MODE_SUMMED
  localparam logic [1:0] MODE_RESERVED = 2'd3;

endpackage

// ----- rtl/iwc_ram.sv -----
`timescale 1ns / 1ps
module iwc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/image_window_convolution.sv -----
// A result is registered four times after the input transfer that completes
//   its window (the item image_width + 1 places after its pixel).
// Throughput: one item per cycle unless output stalls; taps, products, sums
//   and output are four register stages moving when output is empty or ready.
// Reset: asynchronous, active low; clears counters, window, config and valids.
//   Line stores are not cleared; row 0 writes every entry before any read.
`timescale 1ns / 1ps
`include "image_window_convolution_macros.svh"
module image_window_convolution
  import iwc_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int CHANNELS  = CHANNELS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // [7:0] pixel_c0, [15:8] pixel_c1, [23:16] pixel_c2
  input  logic [23:0]      s_axis_tdata,
  // [0] flush
  input  logic             s_axis_tuser,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // [20:0] result_c0, [41:21] result_c1, [62:42] result_c2, [63] zero
  output logic [63:0]      m_axis_tdata,
  output logic             m_axis_tlast
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = (AW + 1 > WIDTH_W) ? AW + 1 : WIDTH_W;

  // configuration
  logic [1:0]          mode_q;
  logic [WIDTH_W-1:0]  width_q;
  logic [HEIGHT_W-1:0] height_q;
  logic [3:0]          shift_q;
  logic [63:0]         bank_a_q, bank_b_q, bank_c_q;
  logic [23:0]         bank_d_q;
  logic                frame_clr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_SPLIT;
      width_q  <= WIDTH_W'(1);
      height_q <= HEIGHT_W'(1);
      shift_q  <= '0;
      bank_a_q <= '0;
      bank_b_q <= '0;
      bank_c_q <= '0;
      bank_d_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MODE:   mode_q   <= cfg_data_i[1:0];
        REG_WIDTH:  width_q  <= cfg_data_i[WIDTH_W-1:0];
        REG_HEIGHT: height_q <= cfg_data_i[HEIGHT_W-1:0];
        REG_SHIFT:  shift_q  <= cfg_data_i[3:0];
        REG_BANK_A: bank_a_q <= cfg_data_i;
        REG_BANK_B: bank_b_q <= cfg_data_i;
        REG_BANK_C: bank_c_q <= cfg_data_i;
        REG_BANK_D: bank_d_q <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  assign frame_clr = cfg_we_i && (cfg_idx_i == REG_WIDTH || cfg_idx_i == REG_HEIGHT);

  logic [NCOEF*COEF_W-1:0] coef_flat;
  assign coef_flat = {bank_d_q, bank_c_q, bank_b_q, bank_a_q};

  // clamped image size
  logic [CW-1:0]       eff_w;
  logic [HEIGHT_W-1:0] eff_h;

  always_comb begin
    if (width_q == '0) begin
      eff_w = CW'(1);
    end else if (CW'(width_q) > CW'(MAX_WIDTH)) begin
      eff_w = CW'(MAX_WIDTH);
    end else begin
      eff_w = CW'(width_q);
    end
    if (height_q == '0) begin
      eff_h = HEIGHT_W'(1);
    end else if (height_q > HEIGHT_LIMIT) begin
      eff_h = HEIGHT_LIMIT;
    end else begin
      eff_h = height_q;
    end
  end

  // handshake and pipeline enable
  logic en, acc, act, drain, emit, last_hit, row0;
  logic v1_q, v2_q, v3_q, v4_q;

  assign en            = !v4_q || m_axis_tready;
  assign s_axis_tready = en;
  assign acc           = s_axis_tvalid && en;

  // position counters
  logic [AW-1:0]    col_q, col_d, col_cur;
  logic [ROW_W-1:0] row_q, row_d;
  logic [CW-1:0]    col_inc;

  assign col_cur  = (CW'(col_q) >= eff_w) ? '0 : col_q;
  assign col_inc  = CW'(col_cur) + CW'(1);
  assign drain    = row_q >= ROW_W'(eff_h);
  assign act      = acc && !(s_axis_tuser && !drain);
  assign row0     = row_q == '0;
  assign emit     = (row_q >= ROW_W'(2)) || (row_q == ROW_W'(1) && col_cur != '0);
  assign last_hit = (row_q == ROW_W'(eff_h) + ROW_W'(1)) && col_cur == '0;

  // line stores with write-to-read forwarding for the one-pixel-wide image
  logic [PIX_W-1:0] up_rdata, lo_rdata, up_rd, lo_rd, up_wdata, pix;
  logic             fwd_up_q, fwd_lo_q;
  logic [PIX_W-1:0] fwd_up_dat_q, fwd_lo_dat_q;

  assign up_rd    = fwd_up_q ? fwd_up_dat_q : up_rdata;
  assign lo_rd    = fwd_lo_q ? fwd_lo_dat_q : lo_rdata;
  assign pix      = drain ? lo_rd : s_axis_tdata;
  assign up_wdata = row0 ? pix : lo_rd;

  iwc_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
    .clk_i   (clk_i),
    .we_i    (act),
    .waddr_i (col_cur),
    .wdata_i (up_wdata),
    .raddr_i (col_d),
    .rdata_o (up_rdata)
  );

  iwc_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_lower (
    .clk_i   (clk_i),
    .we_i    (act),
    .waddr_i (col_cur),
    .wdata_i (pix),
    .raddr_i (col_d),
    .rdata_o (lo_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_up_q <= 1'b0;
      fwd_lo_q <= 1'b0;
    end else begin
      fwd_up_q <= act && (col_d == col_cur);
      fwd_lo_q <= act && (col_d == col_cur);
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_up_dat_q <= up_wdata;
    fwd_lo_dat_q <= pix;
  end

  // 3x3 window, [row][column], column 2 newest
  logic [PIX_W-1:0] win_q [3][3];
  logic [PIX_W-1:0] win_n [3][3];
  logic [PIX_W-1:0] win_d [3][3];
  logic [PIX_W-1:0] tap   [9];
  logic             clr;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_n[r][0] = win_q[r][1];
      win_n[r][1] = win_q[r][2];
    end
    win_n[0][2] = row0 ? pix : up_rd;
    win_n[1][2] = row0 ? pix : lo_rd;
    win_n[2][2] = pix;

    // first column of a row evaluates the window before the shift
    for (int r = 0; r < 3; r++) begin
      if (col_cur == '0) begin
        tap[r*3]     = (eff_w == CW'(1)) ? win_q[r][2] : win_q[r][1];
        tap[r*3 + 1] = win_q[r][2];
        tap[r*3 + 2] = win_q[r][2];
      end else begin
        tap[r*3]     = (col_cur == AW'(1)) ? win_n[r][1] : win_n[r][0];
        tap[r*3 + 1] = win_n[r][1];
        tap[r*3 + 2] = win_n[r][2];
      end
    end

    clr = frame_clr || (act && emit && last_hit);
    col_d = col_q;
    row_d = row_q;
    win_d = win_q;
    if (clr) begin
      col_d = '0;
      row_d = '0;
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          win_d[r][k] = '0;
        end
      end
    end else if (act) begin
      win_d = win_n;
      if (col_inc >= eff_w) begin
        col_d = '0;
        row_d = row_q + ROW_W'(1);
      end else begin
        col_d = col_inc[AW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          win_q[r][k] <= '0;
        end
      end
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      win_q <= win_d;
    end
  end

  // stage 1: taps
  logic [PIX_W-1:0] tap_q [9];
  logic             last1_q, last2_q, last3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      tap_q   <= tap;
      last1_q <= last_hit;
    end
  end

  // stage 2: products
  logic signed [PROD_W-1:0] prod_d [3][9];
  logic signed [PROD_W-1:0] prod_q [3][9];
  logic signed [COEF_W-1:0] cf;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int t = 0; t < 9; t++) begin
        if (mode_q == MODE_SPLIT) begin
          cf = $signed(coef_flat[(ch*9 + t)*COEF_W +: COEF_W]);
        end else begin
          cf = $signed(coef_flat[t*COEF_W +: COEF_W]);
        end
        if (ch < CHANNELS) begin
          prod_d[ch][t] = PROD_W'(cf * $signed({1'b0, tap_q[t][ch*SAMPLE_W +: SAMPLE_W]}));
        end else begin
          prod_d[ch][t] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q  <= prod_d;
      last2_q <= last1_q;
    end
  end

  // stage 3: channel sums
  logic signed [OUT_W-1:0] chsum_d [3];
  logic signed [OUT_W-1:0] chsum_q [3];

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      chsum_d[ch] = '0;
      for (int t = 0; t < 9; t++) begin
        chsum_d[ch] = chsum_d[ch] + OUT_W'(prod_q[ch][t]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      chsum_q <= chsum_d;
      last3_q <= last2_q;
    end
  end

  // stage 4: mode select, floor shift, output register
  logic signed [OUT_W-1:0] all_sum;
  logic signed [OUT_W-1:0] res_d [3];
  logic signed [OUT_W-1:0] res_q [3];
  logic                    tlast_q;

  always_comb begin
    all_sum = chsum_q[0] + chsum_q[1] + chsum_q[2];
    if (mode_q == MODE_PRESERVE) begin
      for (int ch = 0; ch < 3; ch++) begin
        res_d[ch] = chsum_q[ch] >>> shift_q;
      end
    end else begin
      res_d[0] = all_sum >>> shift_q;
      res_d[1] = '0;
      res_d[2] = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q   <= res_d;
      tlast_q <= last3_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= act && emit;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  assign m_axis_tvalid = v4_q;
  assign m_axis_tdata  = {1'b0, res_q[2], res_q[1], res_q[0]};
  assign m_axis_tlast  = tlast_q;

  `IWC_ASSERT(a_col_in_range, CW'(col_q) < eff_w || $past(frame_clr), "column past width")
  `IWC_ASSERT(a_row_bound, row_q <= ROW_W'(eff_h) + ROW_W'(1), "row count past drain")
  `IWC_ASSERT(a_last_restarts, act && emit && last_hit |=> row_q == '0 && col_q == '0, "frame not restarted")
  `IWC_ASSERT_ALWAYS(a_fwd_pair, fwd_up_q == fwd_lo_q, "line store forwarding out of step")

endmodule
